@@ sv/fixed_width_histogram_core_defines.svh @@
// Assertion macros for the histogram core checkers.
`ifndef FIXED_WIDTH_HISTOGRAM_CORE_DEFINES_SVH
`define FIXED_WIDTH_HISTOGRAM_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define FWH_ASSERT_NOW(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) else $error(msg);

// next-cycle implication, checked outside reset
`define FWH_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) else $error(msg);

`endif

@@ sv/fwh_pkg.sv @@
// Shared types and constants for the fixed-width histogram core.
package fwh_pkg;

	localparam int SAMPLE_W = 32;
	localparam int IW_W     = 32;
	localparam int KIND_W   = 2;
	localparam int SEL_W    = 8;
	localparam int IDX_W    = 8;
	localparam int PCT_W    = 15;

	localparam logic [IW_W-1:0]  IW_RESET      = 32'h0001_0000;
	localparam logic [PCT_W-1:0] PCT_FULL      = 15'd25600;
	localparam logic [3:0]       PCT_LAST_STEP = 4'(PCT_W - 1);

	localparam logic REQ_ADD  = 1'b0;
	localparam logic REQ_READ = 1'b1;

	localparam logic [KIND_W-1:0] KIND_FINITE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_BREAK  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_INF    = 2'd2;

	typedef struct packed {
		logic rd_en;
		logic cnt_we;
		logic mark_we;
	} store_ctl_t;

endpackage

@@ sv/fwh_bin_store.sv @@
// Bin count memory and neighbor mark memory, with clearing pass after reset.
module fwh_bin_store #(
	parameter int NUM_BINS = 256,
	parameter int COUNT_BITS = 24,
	localparam int SLOT_W = $clog2(NUM_BINS)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fwh_pkg::store_ctl_t   ctl,
	input  logic [SLOT_W-1:0]     bin_addr,
	input  logic [SLOT_W-1:0]     sel_addr,
	input  logic [SLOT_W-1:0]     wr_addr,
	input  logic [SLOT_W-1:0]     mark_addr,
	input  logic [COUNT_BITS-1:0] wr_count,
	output logic [COUNT_BITS-1:0] bin_rd_count,
	output logic [COUNT_BITS-1:0] sel_rd_count,
	output logic                  sel_rd_mark,
	output logic                  clearing
);

	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_BINS - 1);

	logic [COUNT_BITS-1:0] cnt_mem [NUM_BINS];
	// set when the bin to the left has been touched
	logic                  mark_mem [NUM_BINS];

	logic                  clr_busy_q;
	logic [SLOT_W-1:0]     clr_idx_q;
	logic [COUNT_BITS-1:0] bin_rd_q;
	logic [COUNT_BITS-1:0] sel_rd_q;
	logic                  sel_mark_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + SLOT_W'(1);
			if (clr_idx_q == LAST_SLOT) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			cnt_mem[clr_idx_q]  <= '0;
			mark_mem[clr_idx_q] <= 1'b0;
		end else begin
			if (ctl.cnt_we) begin
				cnt_mem[wr_addr] <= wr_count;
			end
			if (ctl.mark_we) begin
				mark_mem[mark_addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			bin_rd_q   <= cnt_mem[bin_addr];
			sel_rd_q   <= cnt_mem[sel_addr];
			sel_mark_q <= mark_mem[sel_addr];
		end
	end

	assign bin_rd_count = bin_rd_q;
	assign sel_rd_count = sel_rd_q;
	assign sel_rd_mark  = sel_mark_q;
	assign clearing     = clr_busy_q;

endmodule

@@ sv/fwh_pct_div.sv @@
// Two-lane iterative divider for Q7.8 percentages, one quotient bit per cycle.
module fwh_pct_div #(
	parameter int COUNT_BITS = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [COUNT_BITS-1:0]      num_a,
	input  logic [COUNT_BITS-1:0]      num_b,
	input  logic [COUNT_BITS-1:0]      den,
	output logic                       done,
	output logic [fwh_pkg::PCT_W-1:0]  pct_a,
	output logic [fwh_pkg::PCT_W-1:0]  pct_b
);

	localparam int PW = fwh_pkg::PCT_W;
	localparam int DW = COUNT_BITS + PW;

	typedef enum logic [2:0] {
		DV_IDLE  = 3'b001,
		DV_SCALE = 3'b010,
		DV_STEP  = 3'b100
	} dv_state_t;

	dv_state_t             state_q;
	logic [3:0]            step_q;
	logic                  done_q;

	logic [COUNT_BITS-1:0] num_q  [2];
	logic [COUNT_BITS-1:0] den_q;
	logic [COUNT_BITS-1:0] rem_q  [2];
	logic [PW-1:0]         lo_q   [2];
	logic [PW-1:0]         quot_q [2];
	logic                  full_q [2];
	logic                  zero_q;

	logic [DW-1:0]         scaled   [2];
	logic [COUNT_BITS:0]   rem_sh   [2];
	logic [COUNT_BITS:0]   rem_diff [2];
	logic                  fits     [2];

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			scaled[i]   = DW'(num_q[i]) * DW'(fwh_pkg::PCT_FULL);
			rem_sh[i]   = {rem_q[i], lo_q[i][PW-1]};
			rem_diff[i] = rem_sh[i] - {1'b0, den_q};
			fits[i]     = rem_sh[i] >= {1'b0, den_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			unique case (state_q)
				DV_IDLE: begin
					if (start) begin
						state_q <= DV_SCALE;
						done_q  <= 1'b0;
					end
				end
				DV_SCALE: begin
					state_q <= DV_STEP;
					step_q  <= '0;
				end
				DV_STEP: begin
					step_q <= step_q + 4'd1;
					if (step_q == fwh_pkg::PCT_LAST_STEP) begin
						state_q <= DV_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= DV_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == DV_IDLE && start) begin
			num_q[0] <= num_a;
			num_q[1] <= num_b;
			den_q    <= den;
		end
		if (state_q == DV_SCALE) begin
			zero_q <= den_q == '0;
			for (int i = 0; i < 2; i++) begin
				// num < den keeps the quotient below 2^PW, so start at bit PW-1
				rem_q[i]  <= scaled[i][DW-1:PW];
				lo_q[i]   <= scaled[i][PW-1:0];
				quot_q[i] <= '0;
				full_q[i] <= num_q[i] >= den_q;
			end
		end
		if (state_q == DV_STEP) begin
			for (int i = 0; i < 2; i++) begin
				lo_q[i]   <= {lo_q[i][PW-2:0], 1'b0};
				quot_q[i] <= {quot_q[i][PW-2:0], fits[i]};
				rem_q[i]  <= fits[i] ? rem_diff[i][COUNT_BITS-1:0]
				                     : rem_sh[i][COUNT_BITS-1:0];
			end
		end
	end

	assign done  = done_q;
	assign pct_a = zero_q ? '0 : (full_q[0] ? fwh_pkg::PCT_FULL : quot_q[0]);
	assign pct_b = zero_q ? '0 : (full_q[1] ? fwh_pkg::PCT_FULL : quot_q[1]);

endmodule

@@ sv/fixed_width_histogram_core.sv @@
// Flow: an accepted item goes through the bin read (ST_BIN), the update (ST_UPD), the
// percentage divider (ST_DIV) and the output register before out_valid; the next item
// is taken only once the result has been loaded into the output register.
// Reset: asynchronous, active low; afterwards a clearing pass runs through every slot
// of the bin memories with in_ready low (cfg writes are still taken).
// Top level of the fixed-width histogram core.
module fixed_width_histogram_core #(
	parameter int NUM_BINS = 256,
	parameter int COUNT_BITS = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [fwh_pkg::IW_W-1:0]          inverse_width,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              req_type,
	input  logic signed [fwh_pkg::SAMPLE_W-1:0] sample,
	input  logic [fwh_pkg::KIND_W-1:0]        sample_kind,
	input  logic signed [fwh_pkg::SEL_W-1:0]  bin_select,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [COUNT_BITS-1:0]             bin_count,
	output logic                              bin_present,
	output logic [fwh_pkg::PCT_W-1:0]         bin_percent,
	output logic [COUNT_BITS-1:0]             total_count,
	output logic signed [fwh_pkg::IDX_W-1:0]  lowest_bin,
	output logic signed [fwh_pkg::IDX_W-1:0]  highest_bin,
	output logic [fwh_pkg::PCT_W-1:0]         peak_percent,
	output logic                              any_binned,
	output logic                              out_of_range
);

	localparam int SLOT_W = $clog2(NUM_BINS);
	localparam int BW     = SLOT_W + 1;
	localparam int HALF   = NUM_BINS / 2;
	localparam int PW     = fwh_pkg::PCT_W;

	localparam logic signed [32:0]  BIN_LO  = 33'(-HALF);
	localparam logic signed [32:0]  BIN_HI  = 33'(HALF - 1);
	localparam logic signed [32:0]  BIN_OFS = 33'(HALF);
	localparam logic signed [BW-1:0] HI_IDX = BW'(HALF - 1);
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_BIN  = 4'b0010,
		ST_UPD  = 4'b0100,
		ST_DIV  = 4'b1000
	} state_t;

	function automatic logic [fwh_pkg::IDX_W-1:0] idx_clamp(input logic signed [BW-1:0] v);
		logic signed [33:0] e;
		e = $signed({{(34 - BW){v[BW-1]}}, v});
		priority if (e < -34'sd128) begin
			return 8'h80;
		end else if (e > 34'sd127) begin
			return 8'h7F;
		end else begin
			return e[7:0];
		end
	endfunction

	state_t                   state_q;
	logic [fwh_pkg::IW_W-1:0] inv_q;

	logic signed [64:0]       prod_q;
	logic                     req_q;
	logic [fwh_pkg::KIND_W-1:0] kind_q;
	logic signed [fwh_pkg::SEL_W-1:0] sel_q;

	logic [SLOT_W-1:0]        bin_slot_q;
	logic signed [BW-1:0]     bin_idx_q;
	logic                     in_range_q;
	logic                     mark_ok_q;
	logic [SLOT_W-1:0]        sel_slot_q;
	logic                     sel_ok_q;

	logic [COUNT_BITS-1:0]    total_q;
	logic [COUNT_BITS-1:0]    peak_q;
	logic signed [BW-1:0]     low_q;
	logic signed [BW-1:0]     high_q;
	logic                     seen_q;

	logic [COUNT_BITS-1:0]    res_cnt_q;
	logic                     res_present_q;
	logic                     oor_q;

	logic                     out_valid_q;
	logic [COUNT_BITS-1:0]    bin_count_q;
	logic                     bin_present_q;
	logic [PW-1:0]            bin_pct_q;
	logic [COUNT_BITS-1:0]    total_out_q;
	logic [fwh_pkg::IDX_W-1:0] lowest_q;
	logic [fwh_pkg::IDX_W-1:0] highest_q;
	logic [PW-1:0]            peak_pct_q;
	logic                     any_q;
	logic                     oor_out_q;

	logic                     clearing;
	logic                     accept;
	logic                     load_out;
	logic signed [32:0]       bin_full;
	logic signed [32:0]       bin_slot_full;
	logic signed [32:0]       sel_ext;
	logic signed [32:0]       sel_slot_full;
	logic                     in_range_c;
	logic                     sel_ok_c;

	logic [COUNT_BITS-1:0]    bin_rd_count;
	logic [COUNT_BITS-1:0]    sel_rd_count;
	logic                     sel_rd_mark;
	logic [SLOT_W-1:0]        mark_slot;
	logic                     is_add;
	logic                     binning;
	logic                     counted;
	logic [COUNT_BITS-1:0]    new_cnt;
	logic [COUNT_BITS-1:0]    sel_cnt_v;
	logic                     sel_mark_v;
	logic [COUNT_BITS-1:0]    total_v;
	logic [COUNT_BITS-1:0]    peak_v;
	logic signed [BW-1:0]     hi_v;

	fwh_pkg::store_ctl_t      store_ctl;
	logic                     div_done;
	logic [PW-1:0]            pct_a;
	logic [PW-1:0]            pct_b;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE) && !clearing;
	assign accept    = in_valid && in_ready;
	assign load_out  = (state_q == ST_DIV) && div_done && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_q <= fwh_pkg::IW_RESET;
		end else if (cfg_valid) begin
			inv_q <= inverse_width;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (accept) state_q <= ST_BIN;
				ST_BIN:  state_q <= ST_UPD;
				ST_UPD:  state_q <= ST_DIV;
				ST_DIV:  if (load_out) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prod_q <= $signed(sample) * $signed({1'b0, inv_q});
			req_q  <= req_type;
			kind_q <= sample_kind;
			sel_q  <= bin_select;
		end
	end

	// floor of the Q32.32 product
	assign bin_full      = prod_q[64:32];
	assign bin_slot_full = bin_full + BIN_OFS;
	assign in_range_c    = (bin_full >= BIN_LO) && (bin_full <= BIN_HI);
	assign sel_ext       = $signed({{(33 - fwh_pkg::SEL_W){sel_q[fwh_pkg::SEL_W-1]}}, sel_q});
	assign sel_slot_full = sel_ext + BIN_OFS;
	assign sel_ok_c      = (sel_ext >= BIN_LO) && (sel_ext <= BIN_HI);

	always_ff @(posedge clk) begin
		if (state_q == ST_BIN) begin
			bin_slot_q <= bin_slot_full[SLOT_W-1:0];
			bin_idx_q  <= bin_full[BW-1:0];
			in_range_q <= in_range_c;
			mark_ok_q  <= bin_full < BIN_HI;
			sel_slot_q <= sel_slot_full[SLOT_W-1:0];
			sel_ok_q   <= sel_ok_c;
		end
	end

	assign mark_slot = bin_slot_q + SLOT_W'(1);
	assign is_add    = req_q == fwh_pkg::REQ_ADD;
	assign binning   = is_add && (kind_q == fwh_pkg::KIND_FINITE) && in_range_q;
	assign counted   = is_add && (kind_q == fwh_pkg::KIND_FINITE || kind_q == fwh_pkg::KIND_INF);
	assign new_cnt   = (bin_rd_count == CNT_MAX) ? bin_rd_count
	                                             : bin_rd_count + COUNT_BITS'(1);

	always_comb begin
		if (!sel_ok_q) begin
			sel_cnt_v = '0;
		end else if (binning && sel_slot_q == bin_slot_q) begin
			sel_cnt_v = new_cnt;
		end else begin
			sel_cnt_v = sel_rd_count;
		end
		sel_mark_v = sel_ok_q && (sel_rd_mark ||
		             (binning && mark_ok_q && sel_slot_q == mark_slot));
		total_v = (counted && total_q != CNT_MAX) ? total_q + COUNT_BITS'(1) : total_q;
		peak_v  = (binning && new_cnt > peak_q) ? new_cnt : peak_q;
		hi_v    = mark_ok_q ? bin_idx_q + BW'(1) : HI_IDX;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			peak_q  <= '0;
			low_q   <= '0;
			high_q  <= '0;
			seen_q  <= 1'b0;
		end else if (state_q == ST_UPD) begin
			total_q <= total_v;
			peak_q  <= peak_v;
			if (binning) begin
				seen_q <= 1'b1;
				if (!seen_q || bin_idx_q < low_q) begin
					low_q <= bin_idx_q;
				end
				if (!seen_q || hi_v > high_q) begin
					high_q <= hi_v;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_UPD) begin
			res_cnt_q     <= sel_cnt_v;
			res_present_q <= (sel_cnt_v != '0) || sel_mark_v;
			oor_q         <= is_add && (kind_q == fwh_pkg::KIND_FINITE) && !in_range_q;
		end
	end

	assign store_ctl.rd_en   = state_q == ST_BIN;
	assign store_ctl.cnt_we  = (state_q == ST_UPD) && binning;
	assign store_ctl.mark_we = (state_q == ST_UPD) && binning && mark_ok_q;

	fwh_bin_store #(
		.NUM_BINS   (NUM_BINS),
		.COUNT_BITS (COUNT_BITS)
	) u_store (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (store_ctl),
		.bin_addr     (bin_slot_full[SLOT_W-1:0]),
		.sel_addr     (sel_slot_full[SLOT_W-1:0]),
		.wr_addr      (bin_slot_q),
		.mark_addr    (mark_slot),
		.wr_count     (new_cnt),
		.bin_rd_count (bin_rd_count),
		.sel_rd_count (sel_rd_count),
		.sel_rd_mark  (sel_rd_mark),
		.clearing     (clearing)
	);

	fwh_pct_div #(
		.COUNT_BITS (COUNT_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_UPD),
		.num_a  (sel_cnt_v),
		.num_b  (peak_v),
		.den    (total_v),
		.done   (div_done),
		.pct_a  (pct_a),
		.pct_b  (pct_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			bin_count_q   <= res_cnt_q;
			bin_present_q <= res_present_q;
			bin_pct_q     <= pct_a;
			total_out_q   <= total_q;
			lowest_q      <= seen_q ? idx_clamp(low_q) : '0;
			highest_q     <= seen_q ? idx_clamp(high_q) : '0;
			peak_pct_q    <= pct_b;
			any_q         <= seen_q;
			oor_out_q     <= oor_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign bin_count    = bin_count_q;
	assign bin_present  = bin_present_q;
	assign bin_percent  = bin_pct_q;
	assign total_count  = total_out_q;
	assign lowest_bin   = lowest_q;
	assign highest_bin  = highest_q;
	assign peak_percent = peak_pct_q;
	assign any_binned   = any_q;
	assign out_of_range = oor_out_q;

endmodule

@@ sv/fwh_port_check.sv @@
// Port-level checker for the histogram core, bound to the top level.
`include "fixed_width_histogram_core_defines.svh"

module fwh_port_check #(
	parameter int COUNT_BITS = 24
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [COUNT_BITS-1:0]             bin_count,
	input logic [fwh_pkg::PCT_W-1:0]         bin_percent,
	input logic [COUNT_BITS-1:0]             total_count,
	input logic signed [fwh_pkg::IDX_W-1:0]  lowest_bin,
	input logic signed [fwh_pkg::IDX_W-1:0]  highest_bin,
	input logic [fwh_pkg::PCT_W-1:0]         peak_percent,
	input logic                              any_binned
);

	`FWH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(total_count) && $stable(bin_count), "result changed while stalled")
	`FWH_ASSERT_NOW(a_pct_clamp, out_valid, bin_percent <= fwh_pkg::PCT_FULL && peak_percent <= fwh_pkg::PCT_FULL, "percentage above full scale")
	`FWH_ASSERT_NOW(a_bin_le_total, out_valid, bin_count <= total_count, "bin count exceeds total")
	`FWH_ASSERT_NOW(a_empty_range, out_valid && !any_binned, lowest_bin == 8'sd0 && highest_bin == 8'sd0, "range nonzero with nothing binned")
	`FWH_ASSERT_NOW(a_range_order, out_valid && any_binned, lowest_bin <= highest_bin, "lowest bin above highest bin")

endmodule

bind fixed_width_histogram_core fwh_port_check #(.COUNT_BITS(COUNT_BITS)) u_port_check (.*);
